/* sv/gac_pkg.sv */
`default_nettype none

package gac_pkg;

  // Counter and field widths
  localparam int unsigned CntW  = 16;
  localparam int unsigned DistW = 13;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CntW-1:0] CntMax = '1;

  // Register reset values
  localparam logic [CntW-1:0]  PassageTimeoutRst = 16'd5000;
  localparam logic [CntW-1:0]  DetectHoldRst     = 16'd1000;
  localparam logic [CntW-1:0]  ClosingRst        = 16'd1000;
  localparam logic [CntW-1:0]  ErrorRst          = 16'd2000;
  localparam logic [CntW-1:0]  MeasureRst        = 16'd10;
  localparam logic [DistW-1:0] BaseDistRst       = 13'd0;

  // Presence threshold: dist*PresNum < base*PresDen  (dist < 0.95*base)
  localparam int unsigned ProdW = DistW + 5;
  localparam logic [4:0] PresNum = 5'd20;
  localparam logic [4:0] PresDen = 5'd19;

  typedef enum logic [2:0] {
    MODE_WAIT  = 3'd0,
    MODE_PWAIT = 3'd1,
    MODE_DET   = 3'd2,
    MODE_CLOSE = 3'd3,
    MODE_ERR   = 3'd4,
    MODE_DENY  = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    DOOR_NONE  = 2'd0,
    DOOR_ENTRY = 2'd1,
    DOOR_EXIT  = 2'd2,
    DOOR_CLOSE = 2'd3
  } door_t;

  typedef enum logic [2:0] {
    DISP_NONE    = 3'd0,
    DISP_WAITING = 3'd1,
    DISP_WELCOME = 3'd2,
    DISP_GOODBYE = 3'd3,
    DISP_DENIED  = 3'd4,
    DISP_NO_PASS = 3'd5
  } disp_t;

  typedef enum logic [1:0] {
    LOG_NONE    = 2'd0,
    LOG_DENIED  = 2'd1,
    LOG_NO_PASS = 2'd2,
    LOG_PASSED  = 2'd3
  } log_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PASSAGE_TIMEOUT = 3'd0,
    CFG_DETECT_HOLD     = 3'd1,
    CFG_CLOSING         = 3'd2,
    CFG_ERROR           = 3'd3,
    CFG_MEASURE         = 3'd4,
    CFG_BASE_DIST       = 3'd5
  } cfg_idx_t;

  // Saturating tick increment
  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    return (v == CntMax) ? CntMax : v + 1'b1;
  endfunction

endpackage

`default_nettype wire

/* sv/gac_if.sv */
`default_nettype none

// Input channel: one tick item
interface gac_in_if;
  logic       valid;
  logic       ready;
  logic       entry_card_seen;
  logic       exit_card_seen;
  logic       card_allowed;
  logic [12:0] distance_mm;

  modport source (output valid, entry_card_seen, exit_card_seen, card_allowed,
                  distance_mm, input ready);
  modport sink   (input valid, entry_card_seen, exit_card_seen, card_allowed,
                  distance_mm, output ready);
endinterface

// Result channel: one result per tick
interface gac_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] gate_state;
  logic [1:0] door_command;
  logic [2:0] display_message;
  logic [1:0] log_event;
  logic       pass_direction;

  modport source (output valid, gate_state, door_command, display_message, log_event,
                  pass_direction, input ready);
  modport sink   (input valid, gate_state, door_command, display_message, log_event,
                  pass_direction, output ready);
endinterface

`default_nettype wire

/* sv/gate_access_controller_top.sv */
// Channel  Dir  Handshake      Payload
// in_if    in   valid/ready    entry_card_seen, exit_card_seen, card_allowed, distance_mm
// out_if   out  valid/ready    gate_state, door_command, display_message, log_event,
//                              pass_direction
// cfg      in   cfg_we         cfg_idx (3), cfg_wdata (16), no read-back
//
// One item per clock while out_if.ready is high: the tick is evaluated combinationally
// from the input channel and the state registers and is captured in the result register
// when accepted. in_if.ready is high while the result register is empty or being emptied,
// so a new item is taken in the same cycle the previous result is taken.
// rst_n (synchronous, active low) clears the mode, state counter, direction, result valid,
// sets the sample counter to all ones and loads the config registers with their defaults.
`default_nettype none

module gate_access_controller_top
  import gac_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_idx,
  input  wire logic [CfgDataW-1:0] cfg_wdata,
  gac_in_if.sink                 in_if,
  gac_out_if.source              out_if
);

  // Configuration registers
  logic [CntW-1:0]  pto_r, hold_r, close_r, err_r, meas_r;
  logic [DistW-1:0] base_r;

  // Gate state
  mode_t           mode_r, mode_nxt;
  logic [CntW-1:0] state_ticks_r, state_ticks_nxt;
  logic [CntW-1:0] sample_ticks_r, sample_ticks_nxt;
  logic            dir_r, dir_nxt;

  // Result register
  logic  out_valid_r;
  mode_t gate_state_r;
  door_t door_r, door_nxt;
  disp_t disp_r, disp_nxt;
  log_t  log_r, log_nxt;
  logic  pass_dir_r;

  logic in_fire, out_fire;
  logic card, present, sample_due;
  logic restart, sample_clr;
  logic [ProdW-1:0] dist_prod, base_prod;

  assign in_fire  = in_if.valid && in_if.ready;
  assign out_fire = out_valid_r && out_if.ready;
  assign in_if.ready = !out_valid_r || out_if.ready;

  // Config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pto_r   <= PassageTimeoutRst;
      hold_r  <= DetectHoldRst;
      close_r <= ClosingRst;
      err_r   <= ErrorRst;
      meas_r  <= MeasureRst;
      base_r  <= BaseDistRst;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_PASSAGE_TIMEOUT: pto_r   <= cfg_wdata;
        CFG_DETECT_HOLD:     hold_r  <= cfg_wdata;
        CFG_CLOSING:         close_r <= cfg_wdata;
        CFG_ERROR:           err_r   <= cfg_wdata;
        CFG_MEASURE:         meas_r  <= cfg_wdata;
        CFG_BASE_DIST:       base_r  <= cfg_wdata[DistW-1:0];
        default: ;
      endcase
    end
  end

  // Presence: distance nonzero and below 95% of the empty-gate distance
  assign dist_prod  = ProdW'(in_if.distance_mm) * ProdW'(PresNum);
  assign base_prod  = ProdW'(base_r) * ProdW'(PresDen);
  assign present    = (in_if.distance_mm != '0) && (dist_prod < base_prod);
  assign sample_due = sample_ticks_r >= meas_r;
  assign card       = in_if.entry_card_seen || in_if.exit_card_seen;

  // Next state, direction and counter control
  always_comb begin
    mode_nxt   = mode_r;
    dir_nxt    = dir_r;
    restart    = 1'b0;
    sample_clr = 1'b0;
    unique case (mode_r)
      MODE_PWAIT: begin
        if (state_ticks_r >= pto_r) begin
          mode_nxt = MODE_ERR;
          restart  = 1'b1;
        end else if (sample_due) begin
          sample_clr = 1'b1;
          if (present) begin
            mode_nxt = MODE_DET;
            restart  = 1'b1;
          end
        end
      end
      MODE_DET: begin
        // hold check uses the count from before a presence restart
        sample_clr = sample_due;
        restart    = sample_due && present;
        if (state_ticks_r >= hold_r) begin
          mode_nxt = MODE_CLOSE;
          restart  = 1'b1;
        end
      end
      MODE_CLOSE: begin
        if (state_ticks_r >= close_r) begin
          mode_nxt = MODE_WAIT;
          restart  = 1'b1;
        end
      end
      MODE_ERR, MODE_DENY: begin
        if (state_ticks_r >= err_r) begin
          mode_nxt = MODE_WAIT;
          restart  = 1'b1;
        end
      end
      default: begin
        if (card) begin
          restart = 1'b1;
          if (in_if.card_allowed) begin
            mode_nxt = MODE_PWAIT;
            dir_nxt  = !in_if.entry_card_seen;
          end else begin
            mode_nxt = MODE_DENY;
          end
        end
      end
    endcase
    // counters count up at the end of each tick
    state_ticks_nxt  = restart    ? CntW'(1) : sat_inc(state_ticks_r);
    sample_ticks_nxt = sample_clr ? CntW'(1) : sat_inc(sample_ticks_r);
  end

  // Result fields
  always_comb begin
    door_nxt = DOOR_NONE;
    disp_nxt = DISP_NONE;
    log_nxt  = LOG_NONE;
    unique case (mode_r)
      MODE_PWAIT: begin
        if (state_ticks_r >= pto_r) begin
          door_nxt = DOOR_CLOSE;
          disp_nxt = DISP_NO_PASS;
          log_nxt  = LOG_NO_PASS;
        end
      end
      MODE_DET: begin
        if (state_ticks_r >= hold_r) log_nxt = LOG_PASSED;
      end
      MODE_CLOSE: begin
        if (state_ticks_r >= close_r) disp_nxt = DISP_WAITING;
      end
      MODE_ERR, MODE_DENY: begin
        if (state_ticks_r >= err_r) disp_nxt = DISP_WAITING;
      end
      default: begin
        if (card) begin
          if (in_if.card_allowed) begin
            door_nxt = in_if.entry_card_seen ? DOOR_ENTRY : DOOR_EXIT;
            disp_nxt = in_if.entry_card_seen ? DISP_WELCOME : DISP_GOODBYE;
          end else begin
            disp_nxt = DISP_DENIED;
            log_nxt  = LOG_DENIED;
          end
        end
      end
    endcase
  end

  // State update on each accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= MODE_WAIT;
      state_ticks_r  <= '0;
      sample_ticks_r <= CntMax;
      dir_r          <= 1'b0;
    end else if (in_fire) begin
      mode_r         <= mode_nxt;
      state_ticks_r  <= state_ticks_nxt;
      sample_ticks_r <= sample_ticks_nxt;
      dir_r          <= dir_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      gate_state_r <= mode_nxt;
      door_r       <= door_nxt;
      disp_r       <= disp_nxt;
      log_r        <= log_nxt;
      pass_dir_r   <= dir_nxt;
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.gate_state      = gate_state_r;
  assign out_if.door_command    = door_r;
  assign out_if.display_message = disp_r;
  assign out_if.log_event       = log_r;
  assign out_if.pass_direction  = pass_dir_r;

  // Checks
  a_state_holds_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> $stable(mode_r) && $stable(state_ticks_r) && $stable(sample_ticks_r))
    else $error("gate state moved without an accepted item");

  a_passed_closes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && log_r == LOG_PASSED |-> gate_state_r == MODE_CLOSE)
    else $error("passage logged without entering closing");

  a_denied_no_door: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && log_r == LOG_DENIED |-> gate_state_r == MODE_DENY && door_r == DOOR_NONE)
    else $error("denied card with wrong state or door command");

  a_open_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (door_r == DOOR_ENTRY || door_r == DOOR_EXIT) |->
      gate_state_r == MODE_PWAIT && pass_dir_r == (door_r == DOOR_EXIT))
    else $error("door opened against the recorded direction");

endmodule

`default_nettype wire

/* test/tb.sv */
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gac_pkg::*;

  localparam int unsigned Phases     = 10;
  localparam int unsigned PhaseItems = 164;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned IdleLimit  = 2000;
  localparam int unsigned MaxPrinted = 40;

  // One tick item and the result it causes
  typedef struct packed {
    logic             entry;
    logic             exit_card;
    logic             allowed;
    logic [DistW-1:0] dist_mm;
  } gate_tick_t;

  typedef struct packed {
    mode_t mode;
    door_t door;
    disp_t disp;
    log_t  ev;
    logic  dir;
  } gate_res_t;

  // Directed plan: a register write or a tick, with the result typed in where obvious
  typedef struct packed {
    logic        is_cfg;
    cfg_idx_t    reg_idx;
    logic [15:0] reg_val;
    gate_tick_t  tick;
    logic        typed;
    gate_res_t   want;
  } plan_row_t;

  localparam int unsigned PlanRows = 21;
  localparam plan_row_t PLAN [PlanRows] = '{
    // idle tick right after reset
    '{1'b0, CFG_PASSAGE_TIMEOUT, 16'd0, '{1'b0, 1'b0, 1'b0, 13'd0},
      1'b1, '{MODE_WAIT, DOOR_NONE, DISP_NONE, LOG_NONE, 1'b0}},
    // both cards, refused, farthest distance
    '{1'b0, CFG_PASSAGE_TIMEOUT, 16'd0, '{1'b1, 1'b1, 1'b0, 13'd8191},
      1'b1, '{MODE_DENY, DOOR_NONE, DISP_DENIED, LOG_DENIED, 1'b0}},
    '{1'b1, CFG_ERROR, 16'd0, '0, 1'b0, '0},
    // zero error time expires on the first tick
    '{1'b0, CFG_PASSAGE_TIMEOUT, 16'd0, '{1'b0, 1'b0, 1'b0, 13'd0},
      1'b1, '{MODE_WAIT, DOOR_NONE, DISP_WAITING, LOG_NONE, 1'b0}},
    '{1'b1, CFG_BASE_DIST, 16'd8191, '0, 1'b0, '0},
    '{1'b1, CFG_MEASURE, 16'd0, '0, 1'b0, '0},
    '{1'b1, CFG_DETECT_HOLD, 16'd1, '0, 1'b0, '0},
    '{1'b1, CFG_CLOSING, 16'd0, '0, 1'b0, '0},
    '{1'b1, CFG_PASSAGE_TIMEOUT, 16'd65535, '0, 1'b0, '0},
    // both cards allowed: entry wins
    '{1'b0, CFG_PASSAGE_TIMEOUT, 16'd0, '{1'b1, 1'b1, 1'b1, 13'd0},
      1'b1, '{MODE_PWAIT, DOOR_ENTRY, DISP_WELCOME, LOG_NONE, 1'b0}},
    // distances around the presence threshold, restart and hold in detected state
    '{1'b0, CFG_PASSAGE_TIMEOUT, 16'd0, '{1'b0, 1'b0, 1'b0, 13'd7780}, 1'b0, '0},
    '{1'b0, CFG_PASSAGE_TIMEOUT, 16'd0, '{1'b0, 1'b0, 1'b0, 13'd7781}, 1'b0, '0},
    '{1'b0, CFG_PASSAGE_TIMEOUT, 16'd0, '{1'b0, 1'b0, 1'b0, 13'd7782}, 1'b0, '0},
    '{1'b0, CFG_PASSAGE_TIMEOUT, 16'd0, '{1'b0, 1'b0, 1'b0, 13'd0}, 1'b0, '0},
    '{1'b0, CFG_PASSAGE_TIMEOUT, 16'd0, '{1'b0, 1'b0, 1'b1, 13'd0}, 1'b0, '0},
    // exit card allowed
    '{1'b0, CFG_PASSAGE_TIMEOUT, 16'd0, '{1'b0, 1'b1, 1'b1, 13'd100}, 1'b0, '0},
    '{1'b1, CFG_PASSAGE_TIMEOUT, 16'd0, '0, 1'b0, '0},
    // zero passage timeout raises the no-passage error
    '{1'b0, CFG_PASSAGE_TIMEOUT, 16'd0, '{1'b0, 1'b0, 1'b0, 13'd8191},
      1'b1, '{MODE_ERR, DOOR_CLOSE, DISP_NO_PASS, LOG_NO_PASS, 1'b1}},
    '{1'b0, CFG_PASSAGE_TIMEOUT, 16'd0, '{1'b0, 1'b0, 1'b0, 13'd0},
      1'b1, '{MODE_WAIT, DOOR_NONE, DISP_WAITING, LOG_NONE, 1'b1}},
    // refused exit card keeps the last direction
    '{1'b0, CFG_PASSAGE_TIMEOUT, 16'd0, '{1'b0, 1'b1, 1'b0, 13'd1},
      1'b1, '{MODE_DENY, DOOR_NONE, DISP_DENIED, LOG_DENIED, 1'b1}},
    '{1'b0, CFG_PASSAGE_TIMEOUT, 16'd0, '{1'b1, 1'b0, 1'b1, 13'd0}, 1'b0, '0}
  };

  logic clk;
  logic rst_n;
  logic cfg_we;
  cfg_idx_t cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  gac_in_if  in_ch ();
  gac_out_if out_ch ();

  gate_access_controller_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_if     (in_ch),
    .out_if    (out_ch)
  );

  // Gate model state and its copy of the registers
  mode_t            gate_mode = MODE_WAIT;
  logic [CntW-1:0]  mode_ticks = '0;
  logic [CntW-1:0]  sample_age = CntMax;
  logic             pass_dir = 1'b0;
  logic [CntW-1:0]  lim_passage = PassageTimeoutRst;
  logic [CntW-1:0]  lim_hold = DetectHoldRst;
  logic [CntW-1:0]  lim_closing = ClosingRst;
  logic [CntW-1:0]  lim_error = ErrorRst;
  logic [CntW-1:0]  lim_measure = MeasureRst;
  logic [DistW-1:0] base_mm = BaseDistRst;

  gate_res_t   gate_results_due [$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  bit          no_idle = 1'b0;
  bit          hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Someone stands in the gate: closer than 0.95 of the empty-gate distance
  function automatic bit person_seen(logic [DistW-1:0] d);
    return d != 0 && int'(d) * 20 < int'(base_mm) * 19;
  endfunction

  // Advance the gate by one tick and return what it shows
  function automatic gate_res_t gate_tick(gate_tick_t t);
    gate_res_t   r;
    int unsigned elapsed;
    r = '{gate_mode, DOOR_NONE, DISP_NONE, LOG_NONE, pass_dir};
    elapsed = mode_ticks;
    case (gate_mode)
      MODE_PWAIT: begin
        if (elapsed >= lim_passage) begin
          r.ev = LOG_NO_PASS;
          r.disp = DISP_NO_PASS;
          r.door = DOOR_CLOSE;
          gate_mode = MODE_ERR;
          mode_ticks = '0;
        end else if (sample_age >= lim_measure) begin
          if (person_seen(t.dist_mm)) begin
            gate_mode = MODE_DET;
            mode_ticks = '0;
          end
          sample_age = '0;
        end
      end
      MODE_DET: begin
        if (sample_age >= lim_measure) begin
          if (person_seen(t.dist_mm)) mode_ticks = '0;
          sample_age = '0;
        end
        // hold check uses the count from before any restart
        if (elapsed >= lim_hold) begin
          r.ev = LOG_PASSED;
          gate_mode = MODE_CLOSE;
          mode_ticks = '0;
        end
      end
      MODE_CLOSE: begin
        if (elapsed >= lim_closing) begin
          r.disp = DISP_WAITING;
          gate_mode = MODE_WAIT;
          mode_ticks = '0;
        end
      end
      MODE_ERR, MODE_DENY: begin
        if (elapsed >= lim_error) begin
          r.disp = DISP_WAITING;
          gate_mode = MODE_WAIT;
          mode_ticks = '0;
        end
      end
      default: begin
        if (t.entry || t.exit_card) begin
          if (t.allowed) begin
            pass_dir = !t.entry;
            r.disp = t.entry ? DISP_WELCOME : DISP_GOODBYE;
            r.door = t.entry ? DOOR_ENTRY : DOOR_EXIT;
            gate_mode = MODE_PWAIT;
          end else begin
            r.ev = LOG_DENIED;
            r.disp = DISP_DENIED;
            gate_mode = MODE_DENY;
          end
          mode_ticks = '0;
        end
      end
    endcase
    r.mode = gate_mode;
    r.dir = pass_dir;
    if (mode_ticks != CntMax) mode_ticks = mode_ticks + 1'b1;
    if (sample_age != CntMax) sample_age = sample_age + 1'b1;
    return r;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // Distances cluster at zero and around the presence threshold
  function automatic logic [DistW-1:0] pick_dist();
    int          d;
    int unsigned thr;
    int unsigned r;
    thr = (int'(base_mm) * 19) / 20;
    r = $urandom_range(0, 99);
    d = $urandom_range(0, 8191);
    if (r < 15) begin
      d = 0;
    end else if (r < 45) begin
      d = int'(thr) + int'($urandom_range(0, 4)) - 2;
      if (d < 0) d = 0;
      if (d > 8191) d = 8191;
    end else if (r < 70) begin
      d = $urandom_range(1, (thr > 1) ? thr : 1);
    end
    return d[DistW-1:0];
  endfunction

  function automatic gate_tick_t pick_tick();
    gate_tick_t  t;
    int unsigned r;
    r = $urandom_range(0, 99);
    t.entry = (r < 25) || (r >= 40 && r < 50);
    t.exit_card = (r >= 25 && r < 50);
    t.allowed = ($urandom_range(0, 99) < 70);
    t.dist_mm = pick_dist();
    return t;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    mismatches++;
    if (mismatches <= MaxPrinted)
      $display("%0t: result %0d %s: got %0d, expected %0d", $realtime, results_seen,
               what, got, want);
  endtask

  // Offer one tick; the expectation is queued at the edge that takes it
  task automatic send_tick(gate_tick_t t, bit typed = 1'b0, gate_res_t want = '0);
    int unsigned gap;
    gate_res_t   res;
    gap = (no_idle || $urandom_range(0, 99) < 50) ? 0 : idle_len();
    repeat (gap) @(negedge clk) in_ch.valid <= 1'b0;
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.entry_card_seen <= t.entry;
    in_ch.exit_card_seen <= t.exit_card;
    in_ch.card_allowed <= t.allowed;
    in_ch.distance_mm <= t.dist_mm;
    do @(posedge clk); while (!in_ch.ready);
    res = gate_tick(t);
    gate_results_due.push_back(typed ? want : res);
  endtask

  task automatic drain();
    @(negedge clk) in_ch.valid <= 1'b0;
    while (gate_results_due.size() != 0) @(negedge clk);
  endtask

  // Register write, only once the gate has nothing in flight
  task automatic write_reg(cfg_idx_t idx, logic [CfgDataW-1:0] val);
    drain();
    repeat (2) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(negedge clk) cfg_we <= 1'b0;
    case (idx)
      CFG_PASSAGE_TIMEOUT: lim_passage = val;
      CFG_DETECT_HOLD:     lim_hold = val;
      CFG_CLOSING:         lim_closing = val;
      CFG_ERROR:           lim_error = val;
      CFG_MEASURE:         lim_measure = val;
      CFG_BASE_DIST:       base_mm = val[DistW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_phase_regs(int unsigned p);
    case (p)
      0: begin
        write_reg(CFG_PASSAGE_TIMEOUT, PassageTimeoutRst);
        write_reg(CFG_DETECT_HOLD, DetectHoldRst);
        write_reg(CFG_CLOSING, ClosingRst);
        write_reg(CFG_ERROR, ErrorRst);
        write_reg(CFG_MEASURE, MeasureRst);
        write_reg(CFG_BASE_DIST, CfgDataW'(BaseDistRst));
      end
      1: begin
        write_reg(CFG_PASSAGE_TIMEOUT, '1);
        write_reg(CFG_DETECT_HOLD, '1);
        write_reg(CFG_CLOSING, '1);
        write_reg(CFG_ERROR, '1);
        write_reg(CFG_MEASURE, '1);
        write_reg(CFG_BASE_DIST, 16'd8191);
      end
      2: begin
        write_reg(CFG_PASSAGE_TIMEOUT, '0);
        write_reg(CFG_DETECT_HOLD, '0);
        write_reg(CFG_CLOSING, '0);
        write_reg(CFG_ERROR, '0);
        write_reg(CFG_MEASURE, '0);
        write_reg(CFG_BASE_DIST, '0);
      end
      default: begin
        write_reg(CFG_PASSAGE_TIMEOUT, CfgDataW'($urandom_range(0, 40)));
        write_reg(CFG_DETECT_HOLD, CfgDataW'($urandom_range(0, 20)));
        write_reg(CFG_CLOSING, CfgDataW'($urandom_range(0, 15)));
        write_reg(CFG_ERROR, CfgDataW'($urandom_range(0, 15)));
        write_reg(CFG_MEASURE, CfgDataW'($urandom_range(0, 6)));
        write_reg(CFG_BASE_DIST, ($urandom_range(0, 3) == 0)
                                 ? CfgDataW'($urandom_range(0, 40))
                                 : CfgDataW'($urandom_range(0, 8191)));
      end
    endcase
  endtask

  // Result side: random stalls, and one long hold on request
  initial begin
    int unsigned stall;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
        if (!no_idle && $urandom_range(0, 99) < 20) stall = idle_len();
      end
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin : check_results
    gate_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (gate_results_due.size() == 0) begin
        report_mismatch("unexpected result, gate_state", out_ch.gate_state, 0);
      end else begin
        want = gate_results_due.pop_front();
        if (out_ch.gate_state !== want.mode)
          report_mismatch("gate_state", out_ch.gate_state, want.mode);
        if (out_ch.door_command !== want.door)
          report_mismatch("door_command", out_ch.door_command, want.door);
        if (out_ch.display_message !== want.disp)
          report_mismatch("display_message", out_ch.display_message, want.disp);
        if (out_ch.log_event !== want.ev)
          report_mismatch("log_event", out_ch.log_event, want.ev);
        if (out_ch.pass_direction !== want.dir)
          report_mismatch("pass_direction", out_ch.pass_direction, want.dir);
      end
      results_seen++;
    end
  end

  // Watchdog on cycles with no item moving on either side
  always @(posedge clk) begin : watchdog
    int unsigned quiet;
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
    else quiet++;
    if (quiet >= IdleLimit) begin
      $display("FAIL gate_access_controller_top");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_PASSAGE_TIMEOUT;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.entry_card_seen = 1'b0;
    in_ch.exit_card_seen = 1'b0;
    in_ch.card_allowed = 1'b0;
    in_ch.distance_mm = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // directed plan
    for (int i = 0; i < PlanRows; i++) begin
      if (PLAN[i].is_cfg) write_reg(PLAN[i].reg_idx, PLAN[i].reg_val);
      else send_tick(PLAN[i].tick, PLAN[i].typed, PLAN[i].want);
    end

    // random phases, each under its own register setting
    for (int unsigned p = 0; p < Phases; p++) begin
      set_phase_regs(p);
      no_idle = (p == 3 || p == 7);
      for (int unsigned k = 0; k < PhaseItems; k++) begin
        if (p == 4 && k == 60) hold_req = 1'b1;
        if (p == 6 && k == 80) drain();
        send_tick(pick_tick());
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS gate_access_controller_top");
    end else begin
      $display("FAIL gate_access_controller_top");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
sv/gac_pkg.sv
sv/gac_if.sv
sv/gate_access_controller_top.sv
test/tb.sv
